// File: rtl/core/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg
// Shared constants and types for the vertex index compactor.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int VERTEX_DEPTH = 65536;
  localparam int IDX_W        = 16;
  localparam int COUNT_W      = IDX_W + 1;
  localparam int IDX_SPACE    = 1 << IDX_W;
  localparam int DEPTH_W      = 21;
  localparam int TABLE_DEPTH  = (VERTEX_DEPTH < IDX_SPACE) ? VERTEX_DEPTH : IDX_SPACE;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
  localparam int NUM_CORNERS  = 3;

  localparam logic [1:0]         LAST_CORNER = 2'(NUM_CORNERS - 1);
  localparam logic [IDX_W-1:0]   IDX_EXHAUSTED = {IDX_W{1'b1}};
  localparam logic [TABLE_AW-1:0] TABLE_LAST = TABLE_AW'(TABLE_DEPTH - 1);

  typedef logic [IDX_W-1:0] vidx_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FWD   = 6'b000100,
    S_BACK  = 6'b001000,
    S_DEC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// File: rtl/core/vertex_index_compactor.sv
// ----------------------------------------------------------------------------
// vertex_index_compactor
// Remaps the source vertex indices of a triangle stream to a dense numbering
// per part, using a forward and a reverse table in synchronous memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the forward table to zero, one entry a cycle,
// and takes no face until the sweep ends. Each face is then handled one
// corner at a time: a corner passes a forward table read, a reverse table
// read at the index found, and a decide and write back step; the results
// then move into the output register. The next face is accepted only once
// the previous result has been loaded into the output register; the two
// dependent table reads per corner set the pace. A result still waiting in
// the output register holds the finished face, and so the input, until it
// is taken. A corner whose source index lies beyond the table skips the
// reverse table read. Starting a new part costs nothing: an entry counts as
// assigned only when its index is below the running count and the reverse
// table points back at it.
module vertex_index_compactor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                new_part,
  input  logic [15:0]         vert_a,
  input  logic [15:0]         vert_b,
  input  logic [15:0]         vert_c,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_a,
  output logic [15:0]         out_b,
  output logic [15:0]         out_c,
  output logic                fresh_a,
  output logic                fresh_b,
  output logic                fresh_c
);

  vic_pkg::state_t state;
  logic [vic_pkg::TABLE_AW-1:0] clr_addr;
  logic [vic_pkg::COUNT_W-1:0]  next_index;
  logic [1:0]                   corner;
  vic_pkg::vidx_t               vert_q [vic_pkg::NUM_CORNERS];
  vic_pkg::vidx_t               res_idx [vic_pkg::NUM_CORNERS];
  logic [vic_pkg::NUM_CORNERS-1:0] res_fresh;

  vic_pkg::vidx_t fwd_mem [vic_pkg::TABLE_DEPTH];
  vic_pkg::vidx_t back_mem [vic_pkg::IDX_SPACE];
  vic_pkg::vidx_t fwd_q;
  vic_pkg::vidx_t back_q;

  vic_pkg::vidx_t cur_addr;
  logic           in_range;
  logic           hit;
  logic           exhausted;
  logic           assign_new;
  logic           in_xfer;
  logic           out_load;
  logic           last_corner;

  assign in_ready    = (state == vic_pkg::S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign cur_addr    = vert_q[corner];
  assign in_range    = {{(vic_pkg::DEPTH_W - vic_pkg::IDX_W){1'b0}}, cur_addr}
                       < vic_pkg::DEPTH_W'(vic_pkg::VERTEX_DEPTH);
  assign hit         = ({1'b0, fwd_q} < next_index) && (back_q == cur_addr);
  assign exhausted   = next_index[vic_pkg::IDX_W];
  assign assign_new  = (state == vic_pkg::S_DEC) && !hit && !exhausted;
  assign out_load    = (state == vic_pkg::S_DONE) && (!out_valid || out_ready);
  assign last_corner = (corner == vic_pkg::LAST_CORNER);

  // forward table: source vertex to compact index
  always_ff @(posedge clk) begin
    if (state == vic_pkg::S_CLEAR) begin
      fwd_mem[clr_addr] <= '0;
    end else if (assign_new) begin
      fwd_mem[cur_addr[vic_pkg::TABLE_AW-1:0]] <= next_index[vic_pkg::IDX_W-1:0];
    end
    if (state == vic_pkg::S_FWD) begin
      fwd_q <= fwd_mem[cur_addr[vic_pkg::TABLE_AW-1:0]];
    end
  end

  // reverse table: compact index to source vertex
  always_ff @(posedge clk) begin
    if (assign_new) begin
      back_mem[next_index[vic_pkg::IDX_W-1:0]] <= cur_addr;
    end
    if (state == vic_pkg::S_BACK) begin
      back_q <= back_mem[fwd_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vic_pkg::S_CLEAR;
      clr_addr   <= '0;
      next_index <= '0;
      corner     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        vic_pkg::S_CLEAR: begin
          if (clr_addr == vic_pkg::TABLE_LAST) begin
            state <= vic_pkg::S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        vic_pkg::S_IDLE: begin
          if (in_xfer) begin
            if (new_part) begin
              next_index <= '0;
            end
            corner <= '0;
            state  <= vic_pkg::S_FWD;
          end
        end
        vic_pkg::S_FWD: begin
          if (in_range) begin
            state <= vic_pkg::S_BACK;
          end else if (last_corner) begin
            state <= vic_pkg::S_DONE;
          end else begin
            corner <= corner + 1'b1;
          end
        end
        vic_pkg::S_BACK: begin
          state <= vic_pkg::S_DEC;
        end
        vic_pkg::S_DEC: begin
          if (assign_new) begin
            next_index <= next_index + 1'b1;
          end
          if (last_corner) begin
            state <= vic_pkg::S_DONE;
          end else begin
            corner <= corner + 1'b1;
            state  <= vic_pkg::S_FWD;
          end
        end
        vic_pkg::S_DONE: begin
          if (out_load) begin
            state <= vic_pkg::S_IDLE;
          end
        end
        default: begin
          state <= vic_pkg::S_IDLE;
        end
      endcase
    end
  end

  // transaction payload and per-corner results
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vert_q[0] <= vert_a;
      vert_q[1] <= vert_b;
      vert_q[2] <= vert_c;
    end
    if ((state == vic_pkg::S_FWD) && !in_range) begin
      res_idx[corner]   <= '0;
      res_fresh[corner] <= 1'b0;
    end else if (state == vic_pkg::S_DEC) begin
      if (hit) begin
        res_idx[corner]   <= fwd_q;
        res_fresh[corner] <= 1'b0;
      end else if (exhausted) begin
        res_idx[corner]   <= vic_pkg::IDX_EXHAUSTED;
        res_fresh[corner] <= 1'b0;
      end else begin
        res_idx[corner]   <= next_index[vic_pkg::IDX_W-1:0];
        res_fresh[corner] <= 1'b1;
      end
    end
    if (out_load) begin
      out_a   <= res_idx[0];
      out_b   <= res_idx[1];
      out_c   <= res_idx[2];
      fresh_a <= res_fresh[0];
      fresh_b <= res_fresh[1];
      fresh_c <= res_fresh[2];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    next_index <= vic_pkg::COUNT_W'(vic_pkg::IDX_SPACE))
    else $error("next_index beyond index space");

  a_assign_step: assert property (@(posedge clk) disable iff (rst)
    assign_new |=> (next_index == $past(next_index) + 1'b1))
    else $error("assignment did not advance next_index");

  a_part_restart: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && new_part) |=> (next_index == '0))
    else $error("new part did not restart numbering");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == vic_pkg::S_IDLE)))
    else $error("result not presented after load");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for vertex_index_compactor. Faces are driven on a
// valid/ready channel with random gaps, results are taken with random
// back-pressure, and every result is checked against a per-part remap
// predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int FACE_COUNT  = 400;
  localparam int CALM_FACES  = 60;
  localparam int TAIL_CYCLES = 40;
  localparam int STUCK_LIMIT = 300000;

  typedef struct packed {
    vic_pkg::vidx_t idx_a;
    vic_pkg::vidx_t idx_b;
    vic_pkg::vidx_t idx_c;
    logic           fresh_a;
    logic           fresh_b;
    logic           fresh_c;
  } remap_result_t;

  class remap_scoreboard;
    vic_pkg::vidx_t              assigned[vic_pkg::vidx_t];
    logic [vic_pkg::COUNT_W-1:0] next_index;
    remap_result_t               pending_faces[$];
    int                          errors;
    int                          checked;
    int                          parts;
    int                          fresh_corners;

    function new();
      next_index = '0;
      errors = 0;
      checked = 0;
      parts = 0;
      fresh_corners = 0;
    endfunction

    function void remap_corner(input vic_pkg::vidx_t src, output vic_pkg::vidx_t idx,
                               output logic fresh);
      if (int'(src) >= vic_pkg::VERTEX_DEPTH) begin
        idx = '0;
        fresh = 1'b0;
      end else if (assigned.exists(src)) begin
        idx = assigned[src];
        fresh = 1'b0;
      end else if (int'(next_index) >= vic_pkg::IDX_SPACE) begin
        idx = vic_pkg::IDX_EXHAUSTED;
        fresh = 1'b0;
      end else begin
        idx = next_index[vic_pkg::IDX_W-1:0];
        assigned[src] = idx;
        fresh = 1'b1;
        next_index = next_index + 1'b1;
      end
    endfunction

    function void note_face(input logic np, input vic_pkg::vidx_t a,
                            input vic_pkg::vidx_t b, input vic_pkg::vidx_t c);
      remap_result_t r;
      if (np) begin
        assigned.delete();
        next_index = '0;
        parts++;
      end
      remap_corner(a, r.idx_a, r.fresh_a);
      remap_corner(b, r.idx_b, r.fresh_b);
      remap_corner(c, r.idx_c, r.fresh_c);
      fresh_corners += int'(r.fresh_a) + int'(r.fresh_b) + int'(r.fresh_c);
      pending_faces = {pending_faces, r};
    endfunction

    function void check_result(input remap_result_t act);
      remap_result_t exp;
      if (pending_faces.size() == 0) begin
        $error("unexpected transaction: out_a %0d out_b %0d out_c %0d",
               act.idx_a, act.idx_b, act.idx_c);
        errors++;
        return;
      end
      exp = pending_faces.pop_front();
      checked++;
      if (act.idx_a !== exp.idx_a) begin
        $error("out_a mismatch: expected %0d, actual %0d", exp.idx_a, act.idx_a);
        errors++;
      end
      if (act.idx_b !== exp.idx_b) begin
        $error("out_b mismatch: expected %0d, actual %0d", exp.idx_b, act.idx_b);
        errors++;
      end
      if (act.idx_c !== exp.idx_c) begin
        $error("out_c mismatch: expected %0d, actual %0d", exp.idx_c, act.idx_c);
        errors++;
      end
      if (act.fresh_a !== exp.fresh_a) begin
        $error("fresh_a mismatch: expected %0d, actual %0d", exp.fresh_a, act.fresh_a);
        errors++;
      end
      if (act.fresh_b !== exp.fresh_b) begin
        $error("fresh_b mismatch: expected %0d, actual %0d", exp.fresh_b, act.fresh_b);
        errors++;
      end
      if (act.fresh_c !== exp.fresh_c) begin
        $error("fresh_c mismatch: expected %0d, actual %0d", exp.fresh_c, act.fresh_c);
        errors++;
      end
    endfunction

    function void check_leftover();
      if (pending_faces.size() != 0) begin
        $error("%0d expected transactions never arrived", pending_faces.size());
        errors++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  logic           new_part;
  vic_pkg::vidx_t vert_a;
  vic_pkg::vidx_t vert_b;
  vic_pkg::vidx_t vert_c;
  logic           out_valid;
  logic           out_ready;
  vic_pkg::vidx_t out_a;
  vic_pkg::vidx_t out_b;
  vic_pkg::vidx_t out_c;
  logic           fresh_a;
  logic           fresh_b;
  logic           fresh_c;

  remap_scoreboard sb;
  bit              calm;
  int              sent;
  int              stall_left;
  int              stuck_cycles;

  vertex_index_compactor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .new_part  (new_part),
    .vert_a    (vert_a),
    .vert_b    (vert_b),
    .vert_c    (vert_c),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .fresh_a   (fresh_a),
    .fresh_b   (fresh_b),
    .fresh_c   (fresh_c)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst || calm) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result('{out_a, out_b, out_c, fresh_a, fresh_b, fresh_c});
      if (in_valid && in_ready)
        sb.note_face(new_part, vert_a, vert_b, vert_c);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_face(input logic np, input vic_pkg::vidx_t a,
                           input vic_pkg::vidx_t b, input vic_pkg::vidx_t c);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    new_part <= np;
    vert_a <= a;
    vert_b <= b;
    vert_c <= c;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_faces.size() != 0) @(posedge clk);
  endtask

  function automatic vic_pkg::vidx_t pick_vertex(ref vic_pkg::vidx_t pool[$]);
    if ($urandom_range(0, 99) < 85)
      return pool[$urandom_range(0, pool.size() - 1)];
    return vic_pkg::vidx_t'($urandom_range(0, 65535));
  endfunction

  initial begin
    vic_pkg::vidx_t pool[$];
    int             pool_size;
    int             part_faces;
    bit             drained;
    logic           np;

    sb = new();
    calm = 1'b0;
    sent = 0;
    drained = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    new_part = 1'b0;
    vert_a = '0;
    vert_b = '0;
    vert_c = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed faces, the first ones sent before any part was started
    send_face(1'b0, 16'd0, 16'd1, 16'd2);
    send_face(1'b0, 16'd2, 16'd1, 16'd0);
    send_face(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_face(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
    send_face(1'b0, 16'd100, 16'd100, 16'd200);
    send_face(1'b0, 16'd300, 16'd400, 16'd400);
    send_face(1'b0, 16'd500, 16'd600, 16'd500);
    send_face(1'b0, 16'd0, 16'd200, 16'd600);
    send_face(1'b1, 16'h5555, 16'hAAAA, 16'h5555);
    send_face(1'b1, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_face(1'b1, 16'd1, 16'd1, 16'd1);
    send_face(1'b1, 16'd1, 16'd1, 16'd1);
    send_face(1'b0, 16'h8000, 16'h7FFF, 16'h0001);
    send_face(1'b0, 16'h0001, 16'h8000, 16'h7FFF);
    send_face(1'b1, 16'd0, 16'd0, 16'd0);
    send_face(1'b0, 16'hFFFE, 16'h0000, 16'hFFFF);

    while (sent < FACE_COUNT) begin
      pool_size = $urandom_range(1, 40);
      pool.delete();
      for (int i = 0; i < pool_size; i++)
        pool = {pool, vic_pkg::vidx_t'($urandom_range(0, 65535))};
      part_faces = $urandom_range(1, 30);
      for (int f = 0; f < part_faces && sent < FACE_COUNT; f++) begin
        if (f == 0)
          np = ($urandom_range(0, 9) != 0);
        else
          np = ($urandom_range(0, 24) == 0);
        if (sent >= FACE_COUNT - CALM_FACES)
          calm = 1'b1;
        if (!drained && sent >= FACE_COUNT / 2) begin
          drain_results();
          drained = 1'b1;
        end
        send_face(np, pick_vertex(pool), pick_vertex(pool), pick_vertex(pool));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_faces.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_leftover();

    $display("summary: %0d faces in %0d parts, %0d results checked", sent, sb.parts,
             sb.checked);
    $display("summary: %0d corners newly assigned, %0d errors", sb.fresh_corners,
             sb.errors);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/vic_pkg.sv
rtl/core/vertex_index_compactor.sv
verif/tb.sv
